// ===== hw/rtl/stgf_pkg.sv =====
// Shared types and constants for the sparse threshold graph forward block.
package stgf_pkg;

    localparam int CMD_W   = 2;
    localparam int NEUR_W  = 8;
    localparam int ROWO_W  = 6;
    localparam int CHG_W   = 8;
    localparam int ACT_W   = 7;
    localparam int CFG_W   = 7;
    localparam int CFGI_W  = 1;
    localparam int EDGE_W  = 17;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;
    // The remaining encoding does nothing and returns no result.
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    localparam logic [CFGI_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFGI_W-1:0] CFG_LOSS = 1'b1;

    localparam int EDGE_WEIGHT  = 60;
    localparam int FIRE_LEVEL   = 50;
    localparam int CHARGE_LIMIT = 100;
    localparam int INJECT_LEVEL = 100;
    // Beyond this magnitude the scaled charge saturates for any legal retain.
    localparam int PRE_CLAMP    = 202;
    // Reciprocal of 100 scaled by 2^19, exact for magnitudes below 20000.
    localparam int RECIP_100    = 5243;
    localparam int RECIP_SHIFT  = 19;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_EDGE_RD,
        ST_EDGE_CHK,
        ST_EDGE_ACC,
        ST_UPD_RD,
        ST_UPD_MUL,
        ST_UPD_DIV,
        ST_UPD_WR,
        ST_EMIT
    } state_t;

endpackage

// ===== hw/rtl/stgf_if.sv =====
// Request and result channel interfaces for the sparse threshold graph block.
interface stgf_req_if;
    logic                          valid;
    logic                          ready;
    logic [stgf_pkg::CMD_W-1:0]    command;
    logic [stgf_pkg::NEUR_W-1:0]   source_neuron;
    logic [stgf_pkg::NEUR_W-1:0]   dest_neuron;
    logic                          negative_weight;

    modport source (output valid, command, source_neuron, dest_neuron, negative_weight,
                    input ready);
    modport sink   (input valid, command, source_neuron, dest_neuron, negative_weight,
                    output ready);
endinterface

interface stgf_res_if;
    logic                               valid;
    logic                               ready;
    logic [stgf_pkg::ROWO_W-1:0]        row_index;
    logic [stgf_pkg::ROWO_W-1:0]        best_output;
    logic signed [stgf_pkg::CHG_W-1:0]  best_charge;
    logic                               last_in_run;

    modport source (output valid, row_index, best_output, best_charge, last_in_run,
                    input ready);
    modport sink   (input valid, row_index, best_output, best_charge, last_in_run,
                    output ready);
endinterface

// ===== hw/rtl/sparse_threshold_graph_forward.sv =====
// Sparse threshold graph forward pass: edge list, per-row neuron walk and argmax.
// Clear and append requests complete while the block stays idle, so it remains ready for more.
// A run walks each of V rows in turn: a clearing sweep over the row's neurons, then TICK_COUNT
// ticks that each walk the stored edges and then update every neuron, then the hand-over of the
// row result once the output register is free; the shared update datapath serialises this work.
// Reset (rst_n, asynchronous, active low) empties the edge list and restores the control registers.
module sparse_threshold_graph_forward #(
    parameter int MAX_ROWS     = 64,
    parameter int NEURON_RATIO = 3,
    parameter int MAX_EDGES    = 4096,
    parameter int TICK_COUNT   = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    stgf_req_if.sink                      request,
    stgf_res_if.source                    result,
    input  logic                          cfg_write_en,
    input  logic [stgf_pkg::CFGI_W-1:0]   cfg_index,
    input  logic [stgf_pkg::CFG_W-1:0]    cfg_data
);
    import stgf_pkg::*;

    // Every row is an independent network, so rows are processed one after another
    // and the neuron memories only hold one row.
    localparam int MAX_NEURONS = MAX_ROWS * NEURON_RATIO;
    localparam int NW  = $clog2(MAX_NEURONS);
    localparam int NCW = $clog2(MAX_NEURONS + 1);
    localparam int CW  = (NCW > NEUR_W) ? NCW : NEUR_W;
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int VW  = (RCW > CFG_W) ? RCW : CFG_W;
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int TCW = $clog2(TICK_COUNT + 1);
    // A tick sum is at most one full-weight term per edge.
    localparam int SW  = EW + 15;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  rows_reg;
    logic [5:0]        loss_reg;
    logic [ECW-1:0]    count_reg;
    logic [RCW-1:0]    row_reg, row_next;
    logic [NCW-1:0]    idx_reg, idx_next;
    logic [ECW-1:0]    edge_reg, edge_next;
    logic [TCW-1:0]    tick_reg, tick_next;

    logic [EDGE_W-1:0]       edge_mem [MAX_EDGES];
    logic signed [CHG_W-1:0] chg_mem  [MAX_NEURONS];
    logic [ACT_W-1:0]        act_mem  [MAX_NEURONS];
    logic signed [SW-1:0]    sum_mem  [MAX_NEURONS];

    logic [EDGE_W-1:0]       edge_q;
    logic signed [CHG_W-1:0] chg_q;
    logic [ACT_W-1:0]        act_q;
    logic signed [SW-1:0]    sum_q;

    logic [14:0]             prod_reg;
    logic                    neg_reg;
    logic [7:0]              quo_reg;
    logic [RW-1:0]           best_idx_reg;
    logic signed [CHG_W-1:0] best_chg_reg;

    logic                    out_valid_reg;
    logic [ROWO_W-1:0]       out_row_reg;
    logic [ROWO_W-1:0]       out_best_reg;
    logic signed [CHG_W-1:0] out_chg_reg;
    logic                    out_last_reg;

    // Effective configuration, saturated to the legal ranges.
    logic [VW-1:0]  rows_ext;
    logic [RCW-1:0] v_use;
    logic [NCW-1:0] n_use;
    logic [NCW-1:0] out_base;
    logic [5:0]     loss_sat;
    logic [6:0]     retain;

    always_comb
    begin
        rows_ext = VW'(rows_reg);
        if (rows_ext < VW'(2))
            v_use = RCW'(2);
        else if (rows_ext > VW'(MAX_ROWS))
            v_use = RCW'(MAX_ROWS);
        else
            v_use = RCW'(rows_ext);
        n_use    = NCW'(v_use * NEURON_RATIO);
        out_base = n_use - NCW'(v_use);
        if (loss_reg < 6'd1)
            loss_sat = 6'd1;
        else if (loss_reg > 6'd50)
            loss_sat = 6'd50;
        else
            loss_sat = loss_reg;
        retain = 7'd100 - 7'(loss_sat);
    end

    // Edge decode and the weighted term of the accumulate step.
    logic [NEUR_W-1:0]    e_src, e_dst;
    logic                 e_neg;
    logic                 e_skip;
    logic [12:0]          term;
    logic signed [SW-1:0] wt_term;
    logic signed [SW-1:0] acc_val;

    always_comb
    begin
        e_src   = edge_q[7:0];
        e_dst   = edge_q[15:8];
        e_neg   = edge_q[16];
        e_skip  = (CW'(e_src) >= CW'(n_use)) || (CW'(e_dst) >= CW'(n_use));
        term    = 13'(act_q * 13'(EDGE_WEIGHT));
        wt_term = e_neg ? -$signed(SW'(term)) : $signed(SW'(term));
        acc_val = sum_q + wt_term;
    end

    // Neuron update: charge plus sum, clamped early, times retain, divided by 100.
    logic signed [SW:0] csum;
    logic               c_neg;
    logic [7:0]         c_mag;
    logic [14:0]        prod_next;
    logic [27:0]        recip_prod;
    logic [7:0]         q_sat;
    logic signed [CHG_W-1:0] new_chg;
    logic [ACT_W-1:0]   new_act;

    always_comb
    begin
        csum  = (SW+1)'(chg_q) + (SW+1)'(sum_q);
        c_neg = csum < 0;
        if (csum > (SW+1)'(PRE_CLAMP) || csum < -(SW+1)'(PRE_CLAMP))
            c_mag = 8'(PRE_CLAMP);
        else if (c_neg)
            c_mag = 8'(-csum);
        else
            c_mag = 8'(csum);
        prod_next  = 15'(c_mag) * 15'(retain);
        recip_prod = 28'(prod_reg) * 28'(RECIP_100);
        q_sat   = (quo_reg > 8'(CHARGE_LIMIT)) ? 8'(CHARGE_LIMIT) : quo_reg;
        new_chg = neg_reg ? -$signed(q_sat) : $signed(q_sat);
        new_act = (!neg_reg && q_sat > 8'(FIRE_LEVEL)) ? ACT_W'(q_sat - 8'(FIRE_LEVEL))
                                                        : '0;
    end

    logic last_tick, last_idx, last_row, last_edge, in_outputs, take_best;
    logic [NCW-1:0] out_j;

    always_comb
    begin
        last_tick  = tick_reg == TCW'(TICK_COUNT - 1);
        last_idx   = idx_reg == n_use - NCW'(1);
        last_row   = row_reg == v_use - RCW'(1);
        last_edge  = edge_reg + ECW'(1) == count_reg;
        in_outputs = idx_reg >= out_base;
        out_j      = idx_reg - out_base;
        take_best  = last_tick && in_outputs &&
                     (idx_reg == out_base || new_chg > best_chg_reg);
    end

    logic accept;
    assign request.ready = state_reg == ST_IDLE;
    assign accept        = request.valid && request.ready;

    // Sequencer: clear sweep, edge walk, neuron update per tick, then row result.
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        idx_next   = idx_reg;
        edge_next  = edge_reg;
        tick_next  = tick_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && request.command == CMD_RUN)
                begin
                    state_next = ST_INIT;
                    row_next   = '0;
                    idx_next   = '0;
                end
            end
            ST_INIT:
            begin
                idx_next = idx_reg + NCW'(1);
                if (last_idx)
                begin
                    idx_next  = '0;
                    tick_next = '0;
                    edge_next = '0;
                    state_next = (count_reg == '0) ? ST_UPD_RD : ST_EDGE_RD;
                end
            end
            ST_EDGE_RD:
                state_next = ST_EDGE_CHK;
            ST_EDGE_CHK:
            begin
                if (!e_skip)
                    state_next = ST_EDGE_ACC;
                else if (last_edge)
                    state_next = ST_UPD_RD;
                else
                begin
                    edge_next  = edge_reg + ECW'(1);
                    state_next = ST_EDGE_RD;
                end
            end
            ST_EDGE_ACC:
            begin
                if (last_edge)
                    state_next = ST_UPD_RD;
                else
                begin
                    edge_next  = edge_reg + ECW'(1);
                    state_next = ST_EDGE_RD;
                end
            end
            ST_UPD_RD:
                state_next = ST_UPD_MUL;
            ST_UPD_MUL:
                state_next = ST_UPD_DIV;
            ST_UPD_DIV:
                state_next = ST_UPD_WR;
            ST_UPD_WR:
            begin
                idx_next   = idx_reg + NCW'(1);
                state_next = ST_UPD_RD;
                if (last_idx)
                begin
                    idx_next = '0;
                    if (last_tick)
                        state_next = ST_EMIT;
                    else
                    begin
                        tick_next  = tick_reg + TCW'(1);
                        edge_next  = '0;
                        state_next = (count_reg == '0) ? ST_UPD_RD : ST_EDGE_RD;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    if (last_row)
                        state_next = ST_IDLE;
                    else
                    begin
                        row_next   = row_reg + RCW'(1);
                        idx_next   = '0;
                        state_next = ST_INIT;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rows_reg      <= 7'd64;
            loss_reg      <= 6'd15;
            count_reg     <= '0;
            row_reg       <= '0;
            idx_reg       <= '0;
            edge_reg      <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            idx_reg   <= idx_next;
            edge_reg  <= edge_next;
            tick_reg  <= tick_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    CFG_ROWS: rows_reg <= cfg_data;
                    CFG_LOSS: loss_reg <= cfg_data[5:0];
                    default:  ;
                endcase
            end
            if (accept && request.command == CMD_CLEAR)
                count_reg <= '0;
            else if (accept && request.command == CMD_APPEND &&
                     count_reg != ECW'(MAX_EDGES))
                count_reg <= count_reg + ECW'(1);
            if (state_reg == ST_EMIT && !out_valid_reg)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Edge list memory: appended at the fill count, read at the walk pointer.
    always_ff @(posedge clk)
    begin
        if (accept && request.command == CMD_APPEND && count_reg != ECW'(MAX_EDGES))
            edge_mem[count_reg[EW-1:0]] <= {request.negative_weight, request.dest_neuron,
                                            request.source_neuron};
        edge_q <= edge_mem[edge_reg[EW-1:0]];
    end

    // Neuron memories for the row being processed.
    logic [NW-1:0] idx_addr, src_addr, dst_addr, sum_rd_addr, sum_wr_addr;
    logic          chg_we, act_we, sum_we;
    logic signed [CHG_W-1:0] chg_wd;
    logic [ACT_W-1:0]        act_wd;
    logic signed [SW-1:0]    sum_wd;

    always_comb
    begin
        idx_addr    = idx_reg[NW-1:0];
        src_addr    = NW'(e_src);
        dst_addr    = NW'(e_dst);
        sum_rd_addr = (state_reg == ST_EDGE_CHK) ? dst_addr : idx_addr;
        sum_wr_addr = (state_reg == ST_EDGE_ACC) ? dst_addr : idx_addr;
        chg_we = state_reg == ST_INIT || state_reg == ST_UPD_WR;
        act_we = chg_we;
        sum_we = state_reg == ST_INIT || state_reg == ST_UPD_MUL ||
                 state_reg == ST_EDGE_ACC;
        chg_wd = (state_reg == ST_INIT) ? '0 : new_chg;
        if (state_reg == ST_INIT)
            act_wd = (idx_reg == NCW'(row_reg)) ? ACT_W'(INJECT_LEVEL) : '0;
        else
            act_wd = new_act;
        sum_wd = (state_reg == ST_EDGE_ACC) ? acc_val : '0;
    end

    always_ff @(posedge clk)
    begin
        if (chg_we)
            chg_mem[idx_addr] <= chg_wd;
        if (act_we)
            act_mem[idx_addr] <= act_wd;
        if (sum_we)
            sum_mem[sum_wr_addr] <= sum_wd;
        chg_q <= chg_mem[idx_addr];
        act_q <= act_mem[src_addr];
        sum_q <= sum_mem[sum_rd_addr];
    end

    // Update datapath stages and the running argmax.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPD_MUL)
        begin
            prod_reg <= prod_next;
            neg_reg  <= c_neg;
        end
        if (state_reg == ST_UPD_DIV)
            quo_reg <= recip_prod[RECIP_SHIFT+7:RECIP_SHIFT];
        if (state_reg == ST_UPD_WR && take_best)
        begin
            best_idx_reg <= RW'(out_j);
            best_chg_reg <= new_chg;
        end
        if (state_reg == ST_EMIT && !out_valid_reg)
        begin
            out_row_reg  <= ROWO_W'(row_reg);
            out_best_reg <= ROWO_W'(best_idx_reg);
            out_chg_reg  <= best_chg_reg;
            out_last_reg <= last_row;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.row_index   = out_row_reg;
    assign result.best_output = out_best_reg;
    assign result.best_charge = out_chg_reg;
    assign result.last_in_run = out_last_reg;

    // The fill count never passes the capacity of the edge list.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= ECW'(MAX_EDGES))
        else $error("edge count beyond capacity");

    // A result is only loaded while the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !out_valid_reg) |=> out_valid_reg)
        else $error("row result not loaded");

    // Stored charges written by the update stay within the saturation limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPD_WR |-> (new_chg <= 8'sd100 && new_chg >= -8'sd100))
        else $error("charge out of range");

    // The edge list does not change while a run walks it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && $past(state_reg) != ST_IDLE) |-> $stable(count_reg))
        else $error("edge count changed during run");
endmodule
